// ===== rtl/core/dtr_pkg.sv =====
// Shared types, character codes and DFA tables for the token recognizer.
`timescale 1ns / 1ps

package dtr_pkg;

  // Character codes of the alphabet
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_Z     = 8'h7A;

  // Token kinds
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_ID   = 3'd1;
  localparam logic [2:0] KIND_IF   = 3'd2;
  localparam logic [2:0] KIND_REAL = 3'd3;
  localparam logic [2:0] KIND_NUM  = 3'd4;
  localparam logic [2:0] KIND_ERR  = 3'd5;
  localparam logic [2:0] KIND_CMT  = 3'd6;
  localparam logic [2:0] KIND_WS   = 3'd7;

  typedef enum logic [12:0] {
    S_START    = 13'h0001,
    S_I        = 13'h0002,
    S_IF       = 13'h0004,
    S_ID       = 13'h0008,
    S_DOT      = 13'h0010,
    S_REAL_FR  = 13'h0020,
    S_NUM      = 13'h0040,
    S_REAL_INT = 13'h0080,
    S_DASH     = 13'h0100,
    S_OPEN_CMT = 13'h0200,
    S_CMT      = 13'h0400,
    S_WS       = 13'h0800,
    S_ERR      = 13'h1000
  } state_t;

  typedef struct packed {
    logic   dead;
    state_t st;
  } trans_t;

  typedef struct packed {
    logic       token_valid;
    logic [2:0] token_kind;
    logic       newline_out;
    logic       echo_valid;
    logic [7:0] echo_char;
  } result_t;

  function automatic logic [2:0] kind_of(state_t s);
    logic [2:0] k;
    case (s)
      S_I, S_ID:             k = KIND_ID;
      S_IF:                  k = KIND_IF;
      S_REAL_FR, S_REAL_INT: k = KIND_REAL;
      S_NUM:                 k = KIND_NUM;
      S_DOT, S_DASH, S_ERR:  k = KIND_ERR;
      S_CMT:                 k = KIND_CMT;
      S_WS:                  k = KIND_WS;
      default:               k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic trans_t trans(state_t s, logic [7:0] c);
    trans_t t;
    logic   let_c;
    logic   dig_c;
    let_c  = (c >= CH_A) && (c <= CH_Z);
    dig_c  = (c >= CH_0) && (c <= CH_9);
    t.dead = 1'b0;
    t.st   = S_START;
    case (s)
      S_START: begin
        if (c == CH_DASH)       t.st = S_DASH;
        else if (c == CH_SPACE) t.st = S_WS;
        else if (c == CH_DOT)   t.st = S_DOT;
        else if (c == CH_NL)    t.st = S_ERR;
        else if (c == CH_I)     t.st = S_I;
        else if (let_c)         t.st = S_ID;
        else if (dig_c)         t.st = S_NUM;
        else                    t.st = S_ERR;
      end
      S_I: begin
        if (c == CH_F)               t.st = S_IF;
        else if (let_c || dig_c)     t.st = S_ID;
        else                         t.dead = 1'b1;
      end
      S_IF, S_ID: begin
        if (let_c || dig_c) t.st = S_ID;
        else                t.dead = 1'b1;
      end
      S_DOT, S_REAL_FR: begin
        if (dig_c) t.st = S_REAL_FR;
        else       t.dead = 1'b1;
      end
      S_NUM: begin
        if (c == CH_DOT) t.st = S_REAL_INT;
        else if (dig_c)  t.st = S_NUM;
        else             t.dead = 1'b1;
      end
      S_REAL_INT: begin
        if (dig_c) t.st = S_REAL_INT;
        else       t.dead = 1'b1;
      end
      S_DASH: begin
        if (c == CH_DASH) t.st = S_OPEN_CMT;
        else              t.dead = 1'b1;
      end
      S_OPEN_CMT: begin
        if (c == CH_NL)  t.st = S_CMT;
        else if (let_c)  t.st = S_OPEN_CMT;
        else             t.dead = 1'b1;
      end
      S_WS: begin
        if (c == CH_SPACE) t.st = S_WS;
        else               t.dead = 1'b1;
      end
      default: t.dead = 1'b1;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/dtr_if.sv =====
// Valid/ready channel interfaces for character words and result words.
`timescale 1ns / 1ps

interface dtr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface dtr_out_if;
  logic       valid;
  logic       ready;
  logic       token_valid;
  logic [2:0] token_kind;
  logic       newline_out;
  logic       echo_valid;
  logic [7:0] echo_char;

  modport source (output valid, output token_valid, output token_kind, output newline_out,
                  output echo_valid, output echo_char, input ready);
  modport sink   (input valid, input token_valid, input token_kind, input newline_out,
                  input echo_valid, input echo_char, output ready);
endinterface

// ===== rtl/core/dtr_step.sv =====
// One DFA step: next state and result word for one character or end word.
`timescale 1ns / 1ps

module dtr_step (
  input  dtr_pkg::state_t  state,
  input  logic [7:0]       ch,
  input  logic             end_flag,
  output dtr_pkg::state_t  state_nxt,
  output dtr_pkg::result_t res
);

  dtr_pkg::trans_t t_cur;
  dtr_pkg::trans_t t_rst;

  assign t_cur = dtr_pkg::trans(state, ch);
  assign t_rst = dtr_pkg::trans(dtr_pkg::S_START, ch);

  always_comb begin
    res       = '0;
    state_nxt = state;
    if (end_flag) begin
      // flush pending token, back to start
      res.token_valid = (state != dtr_pkg::S_START);
      res.token_kind  = dtr_pkg::kind_of(state);
      state_nxt       = dtr_pkg::S_START;
    end else if (ch == dtr_pkg::CH_NL && state != dtr_pkg::S_OPEN_CMT) begin
      res.newline_out = 1'b1;
    end else begin
      if (t_cur.dead) begin
        // close token, then replay the character from start
        res.token_valid = 1'b1;
        res.token_kind  = dtr_pkg::kind_of(state);
        res.newline_out = 1'b1;
        state_nxt       = t_rst.st;
      end else begin
        state_nxt = t_cur.st;
      end
      if (ch != dtr_pkg::CH_NL && ch != dtr_pkg::CH_SPACE) begin
        res.echo_valid = 1'b1;
        res.echo_char  = ch;
      end
    end
  end

endmodule

// ===== rtl/core/dfa_token_recognizer.sv =====
// Top level: DFA lexer, input register, step logic and result register.
// Each character word passes the input register, then the result register.
// Throughput: one word per cycle unless out_chan stalls; the state register closes
// a loop through the step logic.
// Reset (rst_n low, synchronous): both pipeline registers empty, DFA in start.
`timescale 1ns / 1ps

module dfa_token_recognizer (
  input  logic           clk,
  input  logic           rst_n,
  dtr_in_if.sink         in_chan,
  dtr_out_if.source      out_chan
);

  logic             in_valid_r;
  logic [7:0]       in_ch_r;
  logic             in_end_r;
  dtr_pkg::state_t  state_r;
  dtr_pkg::state_t  state_nxt;
  logic             out_valid_r;
  dtr_pkg::result_t out_res_r;
  dtr_pkg::result_t res;
  logic             out_free;
  logic             adv;
  logic             in_take;

  assign out_free = !out_valid_r || out_chan.ready;
  assign adv      = in_valid_r && out_free;
  assign in_chan.ready = !in_valid_r || out_free;
  assign in_take  = in_chan.valid && in_chan.ready;

  dtr_step u_step (
    .state     (state_r),
    .ch        (in_ch_r),
    .end_flag  (in_end_r),
    .state_nxt (state_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= dtr_pkg::S_START;
    end else begin
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
      // advance the DFA only when the word moves into the result register
      if (adv) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_ch_r  <= in_chan.ch;
      in_end_r <= in_chan.end_of_input;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.token_valid = out_res_r.token_valid;
  assign out_chan.token_kind  = out_res_r.token_kind;
  assign out_chan.newline_out = out_res_r.newline_out;
  assign out_chan.echo_valid  = out_res_r.echo_valid;
  assign out_chan.echo_char   = out_res_r.echo_char;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("DFA state not one-hot");

  a_end_to_start: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_end_r |=> state_r == dtr_pkg::S_START)
    else $error("end word did not return DFA to start");

  a_kind_needs_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.token_valid |-> out_res_r.token_kind == dtr_pkg::KIND_NONE)
    else $error("token kind without token");

  a_echo_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.echo_valid |-> out_res_r.echo_char == 8'h00)
    else $error("echo character without echo");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(state_r))
    else $error("DFA state moved without a word advancing");

endmodule
